@@ src/ghal_pkg.sv @@
// ============================================================================
// ghal_pkg: shared types and constants for the handle allocator
// Request/response word formats, table and stack entry layouts, and the
// state-update bundle passed from the decision logic to the top level.
// ============================================================================
package ghal_pkg;

    localparam int ID_BITS  = 8;
    localparam int GEN_BITS = 16;

    localparam logic [ID_BITS-1:0]  INVALID_ID = {ID_BITS{1'b1}};
    localparam logic [ID_BITS-1:0]  ID_ZERO    = {ID_BITS{1'b0}};
    localparam logic [ID_BITS-1:0]  ID_ONE     = {{(ID_BITS-1){1'b0}}, 1'b1};
    localparam logic [GEN_BITS-1:0] GEN_ZERO   = {GEN_BITS{1'b0}};
    localparam logic [GEN_BITS-1:0] GEN_ONE    = {{(GEN_BITS-1){1'b0}}, 1'b1};
    localparam logic [GEN_BITS-1:0] GEN_MAX    = {GEN_BITS{1'b1}};

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_SUBMIT  = 2'd2,
        OP_REMOVE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_FAILED    = 3'd1,
        ST_RELEASED  = 3'd2,
        ST_IGNORED   = 3'd3,
        ST_FORWARDED = 3'd4,
        ST_REJECTED  = 3'd5
    } status_t;

    typedef struct packed {
        op_t                 op;
        logic [ID_BITS-1:0]  slot_id;
        logic [GEN_BITS-1:0] generation;
        logic                source_present;
        logic                format_match;
        logic                acknowledge;
        logic                queue_full;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [ID_BITS-1:0]  out_slot_id;
        logic [GEN_BITS-1:0] out_generation;
    } resp_t;

    // generation table entry: allocated flag plus current generation
    typedef struct packed {
        logic                allocated;
        logic [GEN_BITS-1:0] generation;
    } tbl_entry_t;

    // free stack entry: freed id plus the generation it will be granted with
    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [GEN_BITS-1:0] generation;
    } stk_entry_t;

    localparam int TBL_BITS = $bits(tbl_entry_t);
    localparam int STK_BITS = $bits(stk_entry_t);

    // state update requested by one request
    typedef struct packed {
        logic               tbl_we;
        logic [ID_BITS-1:0] tbl_addr;
        tbl_entry_t         tbl_data;
        logic               push;
        stk_entry_t         stk_data;
        logic               pop;
        logic               fresh;
    } upd_t;

endpackage

@@ src/ghal_mem.sv @@
// ============================================================================
// ghal_mem: simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module ghal_mem #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 17
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/ghal_decide.sv @@
// ============================================================================
// ghal_decide: per-request decision logic
// Evaluates one request against the looked-up table entry, the stack top and
// the counters; produces the response word and the state update.
// ============================================================================
module ghal_decide (
    input  ghal_pkg::req_t                req,
    input  ghal_pkg::tbl_entry_t          tbl_rd,
    input  ghal_pkg::stk_entry_t          stk_rd,
    input  logic [ghal_pkg::ID_BITS-1:0]  free_count,
    input  logic [ghal_pkg::ID_BITS-1:0]  next_fresh_id,
    output ghal_pkg::resp_t               resp,
    output ghal_pkg::upd_t                upd
);

    logic                          handle_ok;
    logic                          known;
    logic                          live;
    logic [ghal_pkg::GEN_BITS-1:0] bumped_gen;

    // handle checks
    assign handle_ok = (req.slot_id != ghal_pkg::INVALID_ID) &&
                       (req.generation != ghal_pkg::GEN_ZERO);
    assign known     = req.slot_id < next_fresh_id;
    assign live      = known && tbl_rd.allocated && (tbl_rd.generation == req.generation);
    assign bumped_gen = (req.generation == ghal_pkg::GEN_MAX) ? ghal_pkg::GEN_ONE
                                                              : req.generation + ghal_pkg::GEN_ONE;

    // response and update per op
    always_comb begin
        resp.status         = ghal_pkg::ST_IGNORED;
        resp.out_slot_id    = req.slot_id;
        resp.out_generation = req.generation;
        upd                 = '0;
        upd.tbl_addr        = req.slot_id;
        upd.stk_data.id     = req.slot_id;
        upd.stk_data.generation = bumped_gen;

        case (req.op)
            ghal_pkg::OP_ALLOC: begin
                if (free_count != ghal_pkg::ID_ZERO) begin
                    // reuse the most recently freed id
                    upd.pop                 = 1'b1;
                    upd.tbl_we              = 1'b1;
                    upd.tbl_addr            = stk_rd.id;
                    upd.tbl_data.allocated  = 1'b1;
                    upd.tbl_data.generation = stk_rd.generation;
                    resp.status             = ghal_pkg::ST_GRANTED;
                    resp.out_slot_id        = stk_rd.id;
                    resp.out_generation     = stk_rd.generation;
                end else if (next_fresh_id == ghal_pkg::INVALID_ID) begin
                    // fresh ids exhausted
                    resp.status         = ghal_pkg::ST_FAILED;
                    resp.out_slot_id    = ghal_pkg::INVALID_ID;
                    resp.out_generation = ghal_pkg::GEN_ZERO;
                end else begin
                    // never-used id starts at generation 1
                    upd.fresh               = 1'b1;
                    upd.tbl_we              = 1'b1;
                    upd.tbl_addr            = next_fresh_id;
                    upd.tbl_data.allocated  = 1'b1;
                    upd.tbl_data.generation = ghal_pkg::GEN_ONE;
                    resp.status             = ghal_pkg::ST_GRANTED;
                    resp.out_slot_id        = next_fresh_id;
                    resp.out_generation     = ghal_pkg::GEN_ONE;
                end
            end
            ghal_pkg::OP_RELEASE: begin
                if (handle_ok && live && (free_count != ghal_pkg::INVALID_ID)) begin
                    upd.tbl_we              = 1'b1;
                    upd.tbl_data.allocated  = 1'b0;
                    upd.tbl_data.generation = bumped_gen;
                    upd.push                = 1'b1;
                    resp.status             = ghal_pkg::ST_RELEASED;
                end
            end
            ghal_pkg::OP_SUBMIT: begin
                if (!req.source_present || !handle_ok) begin
                    resp.status = ghal_pkg::ST_IGNORED;
                end else if (!live || !req.format_match || req.queue_full) begin
                    resp.status = ghal_pkg::ST_REJECTED;
                end else begin
                    resp.status = ghal_pkg::ST_FORWARDED;
                end
            end
            ghal_pkg::OP_REMOVE: begin
                if (!handle_ok) begin
                    resp.status = ghal_pkg::ST_IGNORED;
                end else if (!live || req.queue_full) begin
                    resp.status = req.acknowledge ? ghal_pkg::ST_REJECTED
                                                  : ghal_pkg::ST_IGNORED;
                end else begin
                    resp.status = ghal_pkg::ST_FORWARDED;
                end
            end
            default: begin
                resp.status = ghal_pkg::ST_IGNORED;
            end
        endcase
    end

endmodule

@@ src/generational_handle_allocator_unit.sv @@
// ============================================================================
// generational_handle_allocator_unit: generation-tagged slot handle allocator
// Grants and releases slot handles through a LIFO free-id stack and checks
// submit/remove handles against the generation table.
// ============================================================================
//
//  Channel | Ports                      | Word
//  --------+----------------------------+-------------------------------------
//  request | s_valid, s_ready, s_data   | op, slot id, generation, flags
//  result  | m_valid, m_ready, m_data   | status, slot id, generation
//
//  One word per cycle sustained while the result channel does not stall; a
//  result word is presented once its request has passed the read stage
//  (table/stack read as the request is taken) and its decision has entered
//  the result register. The single read port of each RAM sets the pace.
//  Reset clears the counters and pipeline valids only; the tables need no
//  clearing pass because an entry is only used once its id has been issued.
//  A stalled result register holds the decision stage, which in turn stops
//  taking requests.
//
module generational_handle_allocator_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ghal_pkg::req_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ghal_pkg::resp_t  m_data
);

    localparam int IDB = ghal_pkg::ID_BITS;

    // pipeline and counter state
    logic                  s1_valid_reg;
    ghal_pkg::req_t        s1_req_reg;
    logic                  m_valid_reg;
    ghal_pkg::resp_t       m_data_reg;
    logic [IDB-1:0]        free_count_reg;
    logic [IDB-1:0]        free_count_next;
    logic [IDB-1:0]        next_fresh_reg;
    logic [IDB-1:0]        next_fresh_next;

    // read-data bypass for a write landing at the same edge as the read
    logic                  byp_tbl_reg;
    ghal_pkg::tbl_entry_t  byp_tbl_data_reg;
    logic                  byp_stk_reg;
    ghal_pkg::stk_entry_t  byp_stk_data_reg;

    logic                           accept;
    logic                           adv;
    logic [ghal_pkg::TBL_BITS-1:0]  tbl_q;
    logic [ghal_pkg::STK_BITS-1:0]  stk_q;
    ghal_pkg::tbl_entry_t           tbl_rd;
    ghal_pkg::stk_entry_t           stk_rd;
    logic [IDB-1:0]                 stk_raddr;
    ghal_pkg::resp_t                resp;
    ghal_pkg::upd_t                 upd;

    // handshake
    assign adv     = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || adv;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // counters after the word now in the decision stage
    always_comb begin
        free_count_next = free_count_reg;
        next_fresh_next = next_fresh_reg;
        if (adv) begin
            if (upd.push) begin
                free_count_next = free_count_reg + ghal_pkg::ID_ONE;
            end else if (upd.pop) begin
                free_count_next = free_count_reg - ghal_pkg::ID_ONE;
            end
            if (upd.fresh) begin
                next_fresh_next = next_fresh_reg + ghal_pkg::ID_ONE;
            end
        end
    end

    // stack top as seen by the incoming word
    assign stk_raddr = free_count_next - ghal_pkg::ID_ONE;

    // generation table: allocated flag and generation per slot
    ghal_mem #(
        .ADDR_BITS (IDB),
        .DATA_BITS (ghal_pkg::TBL_BITS)
    ) u_tbl (
        .aclk  (aclk),
        .we    (adv && upd.tbl_we),
        .waddr (upd.tbl_addr),
        .wdata (upd.tbl_data),
        .re    (accept),
        .raddr (s_data.slot_id),
        .rdata (tbl_q)
    );

    // free-id stack
    ghal_mem #(
        .ADDR_BITS (IDB),
        .DATA_BITS (ghal_pkg::STK_BITS)
    ) u_stk (
        .aclk  (aclk),
        .we    (adv && upd.push),
        .waddr (free_count_reg),
        .wdata (upd.stk_data),
        .re    (accept),
        .raddr (stk_raddr),
        .rdata (stk_q)
    );

    // read stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_req_reg       <= s_data;
            byp_tbl_reg      <= adv && upd.tbl_we && (upd.tbl_addr == s_data.slot_id);
            byp_tbl_data_reg <= upd.tbl_data;
            byp_stk_reg      <= adv && upd.push;
            byp_stk_data_reg <= upd.stk_data;
        end
    end

    assign tbl_rd = byp_tbl_reg ? byp_tbl_data_reg : ghal_pkg::tbl_entry_t'(tbl_q);
    assign stk_rd = byp_stk_reg ? byp_stk_data_reg : ghal_pkg::stk_entry_t'(stk_q);

    // decision
    ghal_decide u_decide (
        .req           (s1_req_reg),
        .tbl_rd        (tbl_rd),
        .stk_rd        (stk_rd),
        .free_count    (free_count_reg),
        .next_fresh_id (next_fresh_reg),
        .resp          (resp),
        .upd           (upd)
    );

    // counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_count_reg <= ghal_pkg::ID_ZERO;
            next_fresh_reg <= ghal_pkg::ID_ZERO;
        end else begin
            free_count_reg <= free_count_next;
            next_fresh_reg <= next_fresh_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= resp;
        end
    end

    // checks
    a_free_le_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= next_fresh_reg)
        else $error("free stack holds more ids than were ever issued");

    a_no_push_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> !(upd.push && upd.pop))
        else $error("push and pop requested by one word");

    a_fresh_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && upd.fresh) |=> next_fresh_reg == $past(next_fresh_reg) + ghal_pkg::ID_ONE)
        else $error("fresh id counter did not advance on a fresh grant");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && upd.pop) |-> free_count_reg != ghal_pkg::ID_ZERO)
        else $error("pop from an empty free stack");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench for generational_handle_allocator_unit
// Drives request words through the valid/ready input channel and predicts
// every result word from a behavioral copy of the allocator's tables, free
// id stack and fresh id counter. Covers handle checks, id exhaustion, LIFO
// reuse under churn and repeated recycling of one slot, with random stalls
// on both sides.
// ============================================================================
module testbench;

    localparam int SLOTS = 2 ** ghal_pkg::ID_BITS;

    typedef logic [ghal_pkg::ID_BITS-1:0]  id_t;
    typedef logic [ghal_pkg::GEN_BITS-1:0] gen_t;

    logic             aclk    = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    ghal_pkg::req_t   s_data  = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    ghal_pkg::resp_t  m_data;

    generational_handle_allocator_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock, 2 ns period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // shadow copy of the allocator state
    gen_t                gen_tbl    [SLOTS];
    bit                  alloc_bits [SLOTS];
    id_t                 free_stack [SLOTS];
    int                  free_cnt;
    int                  fresh_next;
    id_t                 live_ids [$];   // ids currently handed out
    int                  alloc_failures;

    ghal_pkg::resp_t     outcome_q [$];  // result words still to arrive
    int                  mismatches;
    bit                  idle_on;
    int                  stall_left;

    // idle length: mostly none or short, now and then long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // next result word of the allocator for one accepted request word
    function automatic ghal_pkg::resp_t allocator_outcome(ghal_pkg::req_t r);
        ghal_pkg::resp_t o;
        id_t             sid;
        bit              valid_h;
        bit              live;
        bit              unissued;
        o.status         = ghal_pkg::ST_IGNORED;
        o.out_slot_id    = r.slot_id;
        o.out_generation = r.generation;
        valid_h  = (r.slot_id != ghal_pkg::INVALID_ID) && (r.generation != ghal_pkg::GEN_ZERO);
        live     = alloc_bits[r.slot_id] && (gen_tbl[r.slot_id] == r.generation);
        unissued = int'(r.slot_id) >= fresh_next;
        case (r.op)
            ghal_pkg::OP_ALLOC: begin
                if (free_cnt > 0) begin
                    free_cnt--;
                    sid = free_stack[free_cnt];
                end else if (fresh_next >= int'(ghal_pkg::INVALID_ID)) begin
                    alloc_failures++;
                    o.status         = ghal_pkg::ST_FAILED;
                    o.out_slot_id    = ghal_pkg::INVALID_ID;
                    o.out_generation = ghal_pkg::GEN_ZERO;
                    return o;
                end else begin
                    sid = fresh_next[ghal_pkg::ID_BITS-1:0];
                    fresh_next++;
                end
                alloc_bits[sid] = 1'b1;
                if (gen_tbl[sid] == ghal_pkg::GEN_ZERO)
                    gen_tbl[sid] = ghal_pkg::GEN_ONE;
                live_ids = {live_ids, sid};
                o.status         = ghal_pkg::ST_GRANTED;
                o.out_slot_id    = sid;
                o.out_generation = gen_tbl[sid];
            end
            ghal_pkg::OP_RELEASE: begin
                if (valid_h && !unissued && live
                    && free_cnt < int'(ghal_pkg::INVALID_ID)) begin
                    alloc_bits[r.slot_id] = 1'b0;
                    gen_tbl[r.slot_id] = (r.generation == ghal_pkg::GEN_MAX)
                                         ? ghal_pkg::GEN_ONE
                                         : r.generation + ghal_pkg::GEN_ONE;
                    free_stack[free_cnt] = r.slot_id;
                    free_cnt++;
                    foreach (live_ids[i])
                        if (live_ids[i] == r.slot_id) begin
                            live_ids.delete(i);
                            break;
                        end
                    o.status = ghal_pkg::ST_RELEASED;
                end
            end
            ghal_pkg::OP_SUBMIT: begin
                if (!r.source_present || !valid_h)
                    o.status = ghal_pkg::ST_IGNORED;
                else if (unissued || !live || !r.format_match || r.queue_full)
                    o.status = ghal_pkg::ST_REJECTED;
                else
                    o.status = ghal_pkg::ST_FORWARDED;
            end
            default: begin
                if (!valid_h)
                    o.status = ghal_pkg::ST_IGNORED;
                else if (unissued || !live || r.queue_full)
                    o.status = r.acknowledge ? ghal_pkg::ST_REJECTED : ghal_pkg::ST_IGNORED;
                else
                    o.status = ghal_pkg::ST_FORWARDED;
            end
        endcase
        return o;
    endfunction

    function automatic ghal_pkg::req_t mk_req(ghal_pkg::op_t op, id_t id, gen_t gen,
                                              bit src, bit fmt, bit ack, bit full);
        ghal_pkg::req_t r;
        r.op             = op;
        r.slot_id        = id;
        r.generation     = gen;
        r.source_present = src;
        r.format_match   = fmt;
        r.acknowledge    = ack;
        r.queue_full     = full;
        return r;
    endfunction

    function automatic ghal_pkg::op_t pick_op(int alloc_pct, int release_pct, int submit_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < alloc_pct)
            return ghal_pkg::OP_ALLOC;
        if (r < alloc_pct + release_pct)
            return ghal_pkg::OP_RELEASE;
        if (r < alloc_pct + release_pct + submit_pct)
            return ghal_pkg::OP_SUBMIT;
        return ghal_pkg::OP_REMOVE;
    endfunction

    // random request: mostly live handles, then stale, unissued, invalid and raw ones
    function automatic ghal_pkg::req_t random_req(int alloc_pct, int release_pct,
                                                  int submit_pct);
        ghal_pkg::req_t r;
        int             k;
        id_t            id;
        gen_t           gen;
        k   = $urandom_range(0, 99);
        id  = id_t'($urandom);
        gen = gen_t'($urandom);
        if (k < 55 && live_ids.size() > 0) begin
            id  = live_ids[$urandom_range(0, live_ids.size() - 1)];
            gen = gen_tbl[id];
        end else if (k < 70 && fresh_next > 0) begin
            id = id_t'($urandom_range(0, fresh_next - 1));
            case ($urandom_range(0, 2))
                0:       gen = gen_tbl[id];
                1:       gen = gen_tbl[id] - ghal_pkg::GEN_ONE;
                default: gen = gen_tbl[id] + ghal_pkg::GEN_ONE;
            endcase
        end else if (k < 80 && fresh_next < int'(ghal_pkg::INVALID_ID)) begin
            id  = id_t'($urandom_range(fresh_next, int'(ghal_pkg::INVALID_ID) - 1));
            gen = gen_t'($urandom_range(1, int'(ghal_pkg::GEN_MAX)));
        end else if (k < 90) begin
            if ($urandom_range(0, 1) != 0)
                id = ghal_pkg::INVALID_ID;
            else
                gen = ghal_pkg::GEN_ZERO;
        end
        r = mk_req(pick_op(alloc_pct, release_pct, submit_pct), id, gen,
                   $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                   $urandom_range(0, 1) != 0, $urandom_range(0, 4) == 0);
        return r;
    endfunction

    // send one request word and predict its result once it is taken
    task automatic send_req(input ghal_pkg::req_t r);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        outcome_q = {outcome_q, allocator_outcome(r)};
    endtask

    task automatic run_random(int count, int alloc_pct, int release_pct, int submit_pct);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_req(random_req(alloc_pct, release_pct, submit_pct));
        end
    endtask

    // result channel stalls
    always @(negedge aclk) begin
        if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            stall_left = idle_gap();
        end
    end

    task automatic report_mismatch(input string what, input ghal_pkg::resp_t want,
                                   input ghal_pkg::resp_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected status %0d id %0d gen %0d, got status %0d id %0d gen %0d",
                     what, want.status, want.out_slot_id, want.out_generation,
                     got.status, got.out_slot_id, got.out_generation);
    endtask

    // compare each result word with the oldest prediction
    always @(posedge aclk) begin : check_results
        ghal_pkg::resp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("unexpected word", '0, m_data);
            end else begin
                want = outcome_q.pop_front();
                if (m_data.status != want.status)
                    report_mismatch("status", want, m_data);
                else if (m_data.out_slot_id != want.out_slot_id)
                    report_mismatch("slot id", want, m_data);
                else if (m_data.out_generation != want.out_generation)
                    report_mismatch("generation", want, m_data);
            end
        end
    end

    // handle checks and grant/release corner cases on a fresh allocator
    task automatic test_directed();
        idle_on = 1'b1;
        send_req(mk_req(ghal_pkg::OP_SUBMIT, ghal_pkg::ID_ZERO, ghal_pkg::GEN_ONE,
                        1'b1, 1'b1, 1'b0, 1'b0));                       // id not issued
        send_req(mk_req(ghal_pkg::OP_REMOVE, ghal_pkg::INVALID_ID, ghal_pkg::GEN_MAX,
                        1'b0, 1'b0, 1'b1, 1'b1));                       // invalid id
        send_req(mk_req(ghal_pkg::OP_RELEASE, ghal_pkg::ID_ONE, ghal_pkg::GEN_ONE,
                        1'b1, 1'b1, 1'b1, 1'b1));                       // never handed out
        send_req(mk_req(ghal_pkg::OP_ALLOC, ghal_pkg::INVALID_ID, ghal_pkg::GEN_MAX,
                        1'b1, 1'b1, 1'b1, 1'b1));
        send_req(mk_req(ghal_pkg::OP_ALLOC, ghal_pkg::ID_ZERO, ghal_pkg::GEN_ZERO,
                        1'b0, 1'b0, 1'b0, 1'b0));
        send_req(mk_req(ghal_pkg::OP_SUBMIT, ghal_pkg::ID_ZERO, ghal_pkg::GEN_ONE,
                        1'b1, 1'b1, 1'b0, 1'b0));                       // forwarded
        send_req(mk_req(ghal_pkg::OP_SUBMIT, ghal_pkg::ID_ZERO, ghal_pkg::GEN_ONE,
                        1'b0, 1'b1, 1'b0, 1'b0));                       // no source
        send_req(mk_req(ghal_pkg::OP_SUBMIT, ghal_pkg::ID_ZERO, ghal_pkg::GEN_ONE,
                        1'b1, 1'b0, 1'b0, 1'b0));                       // format mismatch
        send_req(mk_req(ghal_pkg::OP_SUBMIT, ghal_pkg::ID_ZERO, ghal_pkg::GEN_ONE,
                        1'b1, 1'b1, 1'b0, 1'b1));                       // queue full
        send_req(mk_req(ghal_pkg::OP_SUBMIT, ghal_pkg::ID_ZERO, ghal_pkg::GEN_ZERO,
                        1'b1, 1'b1, 1'b0, 1'b0));                       // null generation
        send_req(mk_req(ghal_pkg::OP_REMOVE, ghal_pkg::ID_ONE, ghal_pkg::GEN_ONE,
                        1'b0, 1'b0, 1'b0, 1'b0));                       // forwarded
        send_req(mk_req(ghal_pkg::OP_REMOVE, ghal_pkg::ID_ONE, ghal_pkg::GEN_MAX,
                        1'b0, 1'b0, 1'b1, 1'b0));                       // stale, ack
        send_req(mk_req(ghal_pkg::OP_REMOVE, ghal_pkg::ID_ONE, ghal_pkg::GEN_MAX,
                        1'b0, 1'b0, 1'b0, 1'b0));                       // stale, no ack
        send_req(mk_req(ghal_pkg::OP_REMOVE, ghal_pkg::ID_ONE, ghal_pkg::GEN_ONE,
                        1'b0, 1'b0, 1'b1, 1'b1));                       // full, ack
        send_req(mk_req(ghal_pkg::OP_REMOVE, ghal_pkg::ID_ONE, ghal_pkg::GEN_ONE,
                        1'b1, 1'b1, 1'b0, 1'b1));                       // full, no ack
        send_req(mk_req(ghal_pkg::OP_RELEASE, ghal_pkg::ID_ZERO, ghal_pkg::GEN_MAX,
                        1'b0, 1'b0, 1'b0, 1'b0));                       // wrong generation
        send_req(mk_req(ghal_pkg::OP_RELEASE, ghal_pkg::ID_ZERO, ghal_pkg::GEN_ONE,
                        1'b0, 1'b0, 1'b0, 1'b0));                       // released
        send_req(mk_req(ghal_pkg::OP_RELEASE, ghal_pkg::ID_ZERO, ghal_pkg::GEN_ONE,
                        1'b0, 1'b0, 1'b0, 1'b0));                       // already free
        send_req(mk_req(ghal_pkg::OP_SUBMIT, ghal_pkg::ID_ZERO,
                        ghal_pkg::GEN_ONE + ghal_pkg::GEN_ONE,
                        1'b1, 1'b1, 1'b0, 1'b0));                       // not allocated
        send_req(mk_req(ghal_pkg::OP_REMOVE, ghal_pkg::ID_ZERO,
                        ghal_pkg::GEN_ONE + ghal_pkg::GEN_ONE,
                        1'b0, 1'b0, 1'b1, 1'b0));
        send_req(mk_req(ghal_pkg::OP_ALLOC, ghal_pkg::ID_ZERO, ghal_pkg::GEN_ZERO,
                        1'b0, 1'b0, 1'b0, 1'b0));                       // reuses freed id
        send_req(mk_req(ghal_pkg::OP_RELEASE, ghal_pkg::INVALID_ID, ghal_pkg::GEN_MAX,
                        1'b1, 1'b1, 1'b1, 1'b1));                       // invalid id
        send_req(mk_req(ghal_pkg::OP_SUBMIT, ghal_pkg::INVALID_ID, ghal_pkg::GEN_MAX,
                        1'b1, 1'b1, 1'b1, 1'b1));
    endtask

    task automatic test_mixed_traffic();
        run_random(150, 30, 25, 25);
    endtask

    // allocate until every id is out and grants keep failing
    task automatic test_id_exhaustion();
        int n;
        n = 0;
        while (alloc_failures < 6 && n < 600) begin
            if (n % 50 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_req(random_req(80, 8, 6));
            n++;
        end
    endtask

    // heavy release and reuse keeps the free stack deep
    task automatic test_release_churn();
        run_random(150, 25, 45, 15);
    endtask

    // release one slot and take it straight back, many times over
    task automatic test_slot_recycle();
        id_t id;
        idle_on = 1'b0;
        if (live_ids.size() == 0)
            send_req(mk_req(ghal_pkg::OP_ALLOC, ghal_pkg::ID_ZERO, ghal_pkg::GEN_ZERO,
                            1'b0, 1'b0, 1'b0, 1'b0));
        id = live_ids[0];
        for (int i = 0; i < 40; i++) begin
            send_req(mk_req(ghal_pkg::OP_RELEASE, id, gen_tbl[id],
                            1'b0, 1'b0, 1'b0, 1'b0));
            send_req(mk_req(ghal_pkg::OP_ALLOC, ghal_pkg::ID_ZERO, ghal_pkg::GEN_ZERO,
                            1'b0, 1'b0, 1'b0, 1'b0));
        end
        idle_on = 1'b1;
        send_req(mk_req(ghal_pkg::OP_SUBMIT, id, ghal_pkg::GEN_ONE, 1'b1, 1'b1, 1'b0, 1'b0));
        send_req(mk_req(ghal_pkg::OP_SUBMIT, id, gen_tbl[id], 1'b1, 1'b1, 1'b0, 1'b0));
        send_req(mk_req(ghal_pkg::OP_REMOVE, id, ghal_pkg::GEN_MAX, 1'b0, 1'b0, 1'b1, 1'b0));
    endtask

    initial begin : main
        int n;
        for (int i = 0; i < SLOTS; i++) begin
            gen_tbl[i]    = ghal_pkg::GEN_ZERO;
            alloc_bits[i] = 1'b0;
            free_stack[i] = ghal_pkg::ID_ZERO;
        end
        free_cnt       = 0;
        fresh_next     = 0;
        alloc_failures = 0;
        mismatches     = 0;
        stall_left     = 0;
        idle_on        = 1'b1;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_mixed_traffic();
        test_id_exhaustion();
        test_release_churn();
        test_slot_recycle();

        // drain, then give the pipeline time to settle
        @(negedge aclk);
        s_valid <= 1'b0;
        n = 0;
        while (outcome_q.size() != 0 && n < 20000) begin
            @(posedge aclk);
            n++;
        end
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && outcome_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ generational_handle_allocator_unit.f @@
src/ghal_pkg.sv
src/ghal_mem.sv
src/ghal_decide.sv
src/generational_handle_allocator_unit.sv
tb/testbench.sv
